@@ sv/fcs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcs_pkg
// Shared types and constants for the flow controller supervisor.
// ----------------------------------------------------------------------------
package fcs_pkg;

   localparam int unsigned SETPOINT_W = 13;
   localparam int unsigned FRAC_W     = 16;
   localparam int unsigned COUNT_W    = 16;
   localparam int unsigned FLOW_W     = 14;
   localparam int unsigned DAC_W      = 14;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned DEV_W      = 14;
   localparam int unsigned PROD_W     = SETPOINT_W + FRAC_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SETPOINT       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WARN_FRACTION  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FAULT_FRACTION = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SETTLE_LIMIT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CONFIRM_LIMIT  = 3'd4;

   // register reset values
   localparam logic [SETPOINT_W-1:0] SETPOINT_RST       = 13'd0;
   localparam logic [FRAC_W-1:0]     WARN_FRACTION_RST  = 16'd6554;
   localparam logic [FRAC_W-1:0]     FAULT_FRACTION_RST = 16'd32768;
   localparam logic [COUNT_W-1:0]    SETTLE_LIMIT_RST   = 16'd10;
   localparam logic [COUNT_W-1:0]    CONFIRM_LIMIT_RST  = 16'd3;

   // commands
   localparam logic [1:0] CMD_TICK     = 2'd0;
   localparam logic [1:0] CMD_START    = 2'd1;
   localparam logic [1:0] CMD_EVALUATE = 2'd2;
   localparam logic [1:0] CMD_OFF      = 2'd3;

   // event codes
   localparam logic [1:0] EVT_NONE    = 2'd0;
   localparam logic [1:0] EVT_ENTERED = 2'd1;
   localparam logic [1:0] EVT_OFF     = 2'd2;

   localparam logic [DAC_W-1:0]   DRIVE_OFFSET = 14'd8192;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;

   typedef struct packed {
      logic within_warn;   // dev within inner tolerance
      logic below_fault;   // dev strictly below outer tolerance
   } dev_status_type;

endpackage : fcs_pkg
`default_nettype wire

@@ sv/fcs_dev_check.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcs_dev_check
// Deviation classifier: registers the tolerance bands (setpoint times Q0.16
// fraction) and compares the absolute deviation of a flow sample against them.
// ----------------------------------------------------------------------------
module fcs_dev_check
   import fcs_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic [SETPOINT_W-1:0]   setpoint,
   input  wire logic [FRAC_W-1:0]       warn_fraction,
   input  wire logic [FRAC_W-1:0]       fault_fraction,
   input  wire logic signed [FLOW_W-1:0] flow,
   output dev_status_type               status
);

   logic [PROD_W-1:0] warn_band_ff;
   logic [PROD_W-1:0] fault_band_ff;
   logic [PROD_W-1:0] warn_band_in;
   logic [PROD_W-1:0] fault_band_in;

   logic signed [FLOW_W:0] diff;
   logic [DEV_W-1:0]       dev;
   logic [DEV_W+FRAC_W-1:0] dev_scaled;

   // bands follow the registers; configuration must change only while idle, a rule the block leaves to the user
   assign warn_band_in  = PROD_W'(setpoint) * PROD_W'(warn_fraction);
   assign fault_band_in = PROD_W'(setpoint) * PROD_W'(fault_fraction);

   always_ff @(posedge clock) begin
      warn_band_ff  <= warn_band_in;
      fault_band_ff <= fault_band_in;
   end

   always_comb begin
      diff = (FLOW_W+1)'(flow) - $signed({2'b00, setpoint});
      if (diff < 0) begin
         dev = DEV_W'(-diff);
      end else begin
         dev = DEV_W'(diff);
      end
      dev_scaled = {dev, {FRAC_W{1'b0}}};
      status.within_warn = dev_scaled <= (DEV_W+FRAC_W)'(warn_band_ff);
      status.below_fault = dev_scaled <  (DEV_W+FRAC_W)'(fault_band_ff);
   end

endmodule : fcs_dev_check
`default_nettype wire

@@ sv/flow_controller_supervisor.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flow_controller_supervisor
// Supervisor for one mass-flow controller channel: drive code, valve pair,
// settling and monitoring of the measured flow, with ready and fault flags.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req_      in         req_valid/req_stall   command, line_select, measured_flow
//  rsp_      out        rsp_valid/rsp_stall   dac_code, valves, flags, phase, event
//  csr_      in         csr_write             csr_index, csr_data
//
//  One transaction per clock while rsp_stall is low; an accepted request passes
//  the input register, then the state update into the result register.
//  The result register and the state advance together, so throughput is one
//  transaction per cycle whenever rsp_stall is low.
//  rsp_stall holds the result register and backs up into the input register.
//  reset is synchronous and active high; it restores register defaults.
// ----------------------------------------------------------------------------
module flow_controller_supervisor
   import fcs_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_command,
   input  wire logic                     req_line_select,
   input  wire logic signed [FLOW_W-1:0] req_measured_flow,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [DAC_W-1:0]              rsp_dac_code,
   output logic                          rsp_valve_zero,
   output logic                          rsp_valve_one,
   output logic                          rsp_ready_res,
   output logic                          rsp_not_reached_fault,
   output logic                          rsp_deviation_warning,
   output logic                          rsp_deviation_fault,
   output logic [1:0]                    rsp_phase,
   output logic [1:0]                    rsp_event_res,
   input  wire logic                     csr_write,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_data
);

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_STARTING = 2'd1,
      PH_SETTLING = 2'd2,
      PH_MONITOR  = 2'd3
   } phase_type;

   // configuration
   logic [SETPOINT_W-1:0] setpoint_ff;
   logic [FRAC_W-1:0]     warn_fraction_ff;
   logic [FRAC_W-1:0]     fault_fraction_ff;
   logic [COUNT_W-1:0]    settle_limit_ff;
   logic [COUNT_W-1:0]    confirm_limit_ff;

   // input register
   logic                     s1_valid_ff;
   logic [1:0]               s1_command_ff;
   logic                     s1_line_ff;
   logic signed [FLOW_W-1:0] s1_flow_ff;

   // supervisor state
   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] settle_ff, settle_in;
   logic [COUNT_W-1:0] confirm_ff, confirm_in;
   logic               ready_ff, ready_in;
   logic               notreach_ff, notreach_in;
   logic               warn_ff, warn_in;
   logic               fault_ff, fault_in;
   logic [1:0]         valve_ff, valve_in;
   logic               drive_ff, drive_in;
   logic [1:0]         event_in;

   logic               rsp_valid_ff;
   logic               advance;
   logic               s1_take;
   dev_status_type     dev_status;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign s1_take   = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;

   fcs_dev_check u_dev_check (
      .clock          (clock),
      .setpoint       (setpoint_ff),
      .warn_fraction  (warn_fraction_ff),
      .fault_fraction (fault_fraction_ff),
      .flow           (s1_flow_ff),
      .status         (dev_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff       <= SETPOINT_RST;
         warn_fraction_ff  <= WARN_FRACTION_RST;
         fault_fraction_ff <= FAULT_FRACTION_RST;
         settle_limit_ff   <= SETTLE_LIMIT_RST;
         confirm_limit_ff  <= CONFIRM_LIMIT_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_SETPOINT:       setpoint_ff       <= csr_data[SETPOINT_W-1:0];
            REG_WARN_FRACTION:  warn_fraction_ff  <= csr_data;
            REG_FAULT_FRACTION: fault_fraction_ff <= csr_data;
            REG_SETTLE_LIMIT:   settle_limit_ff   <= csr_data;
            REG_CONFIRM_LIMIT:  confirm_limit_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      settle_in   = settle_ff;
      confirm_in  = confirm_ff;
      ready_in    = ready_ff;
      notreach_in = notreach_ff;
      warn_in     = warn_ff;
      fault_in    = fault_ff;
      valve_in    = valve_ff;
      drive_in    = drive_ff;
      event_in    = EVT_NONE;
      case (s1_command_ff)
         CMD_TICK: begin
            if (settle_ff != COUNT_MAX) settle_in = settle_ff + 1'b1;
            if (confirm_ff != COUNT_MAX) confirm_in = confirm_ff + 1'b1;
         end
         CMD_START: begin
            phase_in    = PH_SETTLING;
            settle_in   = '0;
            confirm_in  = '0;
            {ready_in, notreach_in, warn_in, fault_in} = '0;
            valve_in    = s1_line_ff ? 2'b10 : 2'b01;
            drive_in    = 1'b1;
         end
         CMD_EVALUATE: begin
            case (phase_ff)
               PH_STARTING: begin
                  // a sample while starting restarts the channel
                  phase_in    = PH_SETTLING;
                  settle_in   = '0;
                  confirm_in  = '0;
                  {ready_in, notreach_in, warn_in, fault_in} = '0;
                  valve_in    = s1_line_ff ? 2'b10 : 2'b01;
                  drive_in    = 1'b1;
               end
               PH_SETTLING: begin
                  if (dev_status.within_warn) begin
                     if (confirm_ff > confirm_limit_ff) begin
                        notreach_in = 1'b0;
                        ready_in    = 1'b1;
                        event_in    = EVT_ENTERED;
                        phase_in    = PH_MONITOR;
                     end
                  end else begin
                     confirm_in = '0;
                     if (settle_ff > settle_limit_ff) notreach_in = 1'b1;
                  end
               end
               PH_MONITOR: begin
                  warn_in  = !dev_status.within_warn && dev_status.below_fault;
                  fault_in = !dev_status.within_warn && !dev_status.below_fault;
               end
               default: ;
            endcase
         end
         default: begin
            // switch off: counters are left as they are; ticks still advance them
            phase_in = PH_IDLE;
            {ready_in, notreach_in, warn_in, fault_in} = '0;
            valve_in = 2'b00;
            drive_in = 1'b0;
            event_in = EVT_OFF;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         settle_ff    <= '0;
         confirm_ff   <= '0;
         ready_ff     <= 1'b0;
         notreach_ff  <= 1'b0;
         warn_ff      <= 1'b0;
         fault_ff     <= 1'b0;
         valve_ff     <= 2'b00;
         drive_ff     <= 1'b0;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_take) begin
            phase_ff    <= phase_in;
            settle_ff   <= settle_in;
            confirm_ff  <= confirm_in;
            ready_ff    <= ready_in;
            notreach_ff <= notreach_in;
            warn_ff     <= warn_in;
            fault_ff    <= fault_in;
            valve_ff    <= valve_in;
            drive_ff    <= drive_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_command_ff <= req_command;
         s1_line_ff    <= req_line_select;
         s1_flow_ff    <= req_measured_flow;
      end
      if (s1_take) begin
         rsp_dac_code          <= drive_in ? DRIVE_OFFSET + DAC_W'(setpoint_ff)
                                           : DRIVE_OFFSET;
         rsp_valve_zero        <= valve_in[0];
         rsp_valve_one         <= valve_in[1];
         rsp_ready_res         <= ready_in;
         rsp_not_reached_fault <= notreach_in;
         rsp_deviation_warning <= warn_in;
         rsp_deviation_fault   <= fault_in;
         rsp_phase             <= phase_in;
         rsp_event_res         <= event_in;
      end
   end

   a_one_valve : assert property (@(posedge clock) disable iff (reset)
      valve_ff != 2'b11)
      else $error("both valves open");

   a_drive_valve : assert property (@(posedge clock) disable iff (reset)
      drive_ff == (valve_ff != 2'b00))
      else $error("drive and valve state disagree");

   a_ready_monitor : assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> phase_ff == PH_MONITOR)
      else $error("ready flag outside monitoring");

   a_entered_phase : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_event_res == EVT_ENTERED) |-> rsp_phase == PH_MONITOR)
      else $error("entered event without monitoring phase");

   a_state_hold : assert property (@(posedge clock) disable iff (reset)
      !s1_take |=> $stable(phase_ff) && $stable(settle_ff) && $stable(confirm_ff))
      else $error("state changed without a transaction");

endmodule : flow_controller_supervisor
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the flow controller supervisor. A short directed run
// walks settling, ready, warning and fault bands and their edges. Random
// start/tick/evaluate/off sequences follow under several register settings, with
// random idling on both channels. Every result transaction is compared field
// by field with a behavioural prediction of the channel state.
// ----------------------------------------------------------------------------
module tb_top;
   import fcs_pkg::*;

   localparam logic [1:0] PH_IDLE       = 2'd0;
   localparam logic [1:0] PH_STARTING   = 2'd1;
   localparam logic [1:0] PH_SETTLING   = 2'd2;
   localparam logic [1:0] PH_MONITORING = 2'd3;

   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [DAC_W-1:0] dac_code;
      logic             valve_zero;
      logic             valve_one;
      logic             ready_res;
      logic             not_reached_fault;
      logic             deviation_warning;
      logic             deviation_fault;
      logic [1:0]       phase;
      logic [1:0]       event_res;
   } flow_status_type;

   typedef struct {
      logic [SETPOINT_W-1:0] setpoint;
      logic [FRAC_W-1:0]     warn_fraction;
      logic [FRAC_W-1:0]     fault_fraction;
      logic [COUNT_W-1:0]    settle_limit;
      logic [COUNT_W-1:0]    confirm_limit;
   } channel_settings_type;

   // Predicts the channel status after each request and holds the statuses
   // still owed by the block.
   class flow_supervisor_model;
      logic [SETPOINT_W-1:0] setpoint      = SETPOINT_RST;
      logic [FRAC_W-1:0]     warn_frac     = WARN_FRACTION_RST;
      logic [FRAC_W-1:0]     fault_frac    = FAULT_FRACTION_RST;
      logic [COUNT_W-1:0]    settle_limit  = SETTLE_LIMIT_RST;
      logic [COUNT_W-1:0]    confirm_limit = CONFIRM_LIMIT_RST;
      logic [1:0]            phase_q       = PH_IDLE;
      logic [COUNT_W-1:0]    settle_cnt    = '0;
      logic [COUNT_W-1:0]    confirm_cnt   = '0;
      logic                  ready_q       = 1'b0;
      logic                  nreach_q      = 1'b0;
      logic                  warn_q        = 1'b0;
      logic                  fault_q       = 1'b0;
      logic [1:0]            valves        = 2'b00;
      logic                  drive_on      = 1'b0;
      flow_status_type       pending[$];
      int                    failures      = 0;

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_SETPOINT:       setpoint      = data[SETPOINT_W-1:0];
            REG_WARN_FRACTION:  warn_frac     = data;
            REG_FAULT_FRACTION: fault_frac    = data;
            REG_SETTLE_LIMIT:   settle_limit  = data;
            REG_CONFIRM_LIMIT:  confirm_limit = data;
            default: ;
         endcase
      endfunction

      function void start_channel(logic line);
         drive_on    = 1'b1;
         valves      = line ? 2'b10 : 2'b01;
         ready_q     = 1'b0;
         nreach_q    = 1'b0;
         warn_q      = 1'b0;
         fault_q     = 1'b0;
         settle_cnt  = '0;
         confirm_cnt = '0;
         phase_q     = PH_SETTLING;
      endfunction

      function void note_request(logic [1:0] cmd, logic line,
                                 logic signed [FLOW_W-1:0] flow);
         flow_status_type s;
         logic [1:0]      evt;
         int              dev;
         logic [63:0]     dev_scaled;
         logic            in_warn;
         logic            below_fault;
         evt = EVT_NONE;
         dev = int'(flow) - int'(setpoint);
         if (dev < 0) dev = -dev;
         dev_scaled  = 64'(dev) << 16;
         in_warn     = dev_scaled <= 64'(setpoint) * 64'(warn_frac);
         below_fault = dev_scaled <  64'(setpoint) * 64'(fault_frac);
         case (cmd)
            CMD_TICK: begin
               if (settle_cnt != COUNT_MAX) settle_cnt++;
               if (confirm_cnt != COUNT_MAX) confirm_cnt++;
            end
            CMD_START: start_channel(line);
            CMD_EVALUATE: begin
               case (phase_q)
                  PH_STARTING: start_channel(line);
                  PH_SETTLING: begin
                     if (in_warn) begin
                        if (confirm_cnt > confirm_limit) begin
                           nreach_q = 1'b0;
                           ready_q  = 1'b1;
                           evt      = EVT_ENTERED;
                           phase_q  = PH_MONITORING;
                        end
                     end else begin
                        confirm_cnt = '0;
                        if (settle_cnt > settle_limit) nreach_q = 1'b1;
                     end
                  end
                  PH_MONITORING: begin
                     warn_q  = !in_warn && below_fault;
                     fault_q = !in_warn && !below_fault;
                  end
                  default: ;
               endcase
            end
            default: begin
               phase_q  = PH_IDLE;
               ready_q  = 1'b0;
               nreach_q = 1'b0;
               warn_q   = 1'b0;
               fault_q  = 1'b0;
               valves   = 2'b00;
               drive_on = 1'b0;
               evt      = EVT_OFF;
            end
         endcase
         s.dac_code          = drive_on ? DAC_W'(setpoint) + DRIVE_OFFSET : DRIVE_OFFSET;
         s.valve_zero        = valves[0];
         s.valve_one         = valves[1];
         s.ready_res         = ready_q;
         s.not_reached_fault = nreach_q;
         s.deviation_warning = warn_q;
         s.deviation_fault   = fault_q;
         s.phase             = phase_q;
         s.event_res         = evt;
         pending.push_back(s);
      endfunction

      function string show(flow_status_type s);
         return $sformatf("dac=%0d v0=%0b v1=%0b rdy=%0b nr=%0b warn=%0b flt=%0b ph=%0d ev=%0d",
                          s.dac_code, s.valve_zero, s.valve_one, s.ready_res,
                          s.not_reached_fault, s.deviation_warning, s.deviation_fault,
                          s.phase, s.event_res);
      endfunction

      function void check_status(flow_status_type got);
         flow_status_type want;
         string           diff;
         if (pending.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("[%0t] unexpected result transaction: %s", $realtime, show(got));
            return;
         end
         want = pending.pop_front();
         diff = "";
         if (got.dac_code          !== want.dac_code)          diff = {diff, " dac_code"};
         if (got.valve_zero        !== want.valve_zero)        diff = {diff, " valve_zero"};
         if (got.valve_one         !== want.valve_one)         diff = {diff, " valve_one"};
         if (got.ready_res         !== want.ready_res)         diff = {diff, " ready_res"};
         if (got.not_reached_fault !== want.not_reached_fault) diff = {diff, " not_reached"};
         if (got.deviation_warning !== want.deviation_warning) diff = {diff, " warning"};
         if (got.deviation_fault   !== want.deviation_fault)   diff = {diff, " fault"};
         if (got.phase             !== want.phase)             diff = {diff, " phase"};
         if (got.event_res         !== want.event_res)         diff = {diff, " event_res"};
         if (diff != "") begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("[%0t] mismatch in%s\n   expected %s\n   actual   %s",
                        $realtime, diff, show(want), show(got));
         end
      endfunction
   endclass

   logic                     clock             = 1'b0;
   logic                     reset             = 1'b1;
   logic                     req_valid         = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_command       = CMD_TICK;
   logic                     req_line_select   = 1'b0;
   logic signed [FLOW_W-1:0] req_measured_flow = '0;
   logic                     rsp_valid;
   logic                     rsp_stall         = 1'b0;
   logic [DAC_W-1:0]         rsp_dac_code;
   logic                     rsp_valve_zero;
   logic                     rsp_valve_one;
   logic                     rsp_ready_res;
   logic                     rsp_not_reached_fault;
   logic                     rsp_deviation_warning;
   logic                     rsp_deviation_fault;
   logic [1:0]               rsp_phase;
   logic [1:0]               rsp_event_res;
   logic                     csr_write         = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index         = REG_SETPOINT;
   logic [CSR_DATA_W-1:0]    csr_data          = '0;

   flow_supervisor_model model = new;
   channel_settings_type cur;
   bit                   sender_idling   = 1'b1;
   bit                   receiver_idling = 1'b1;
   bit                   hold_request    = 1'b0;
   int                   idle_cycles     = 0;

   flow_controller_supervisor uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_command           (req_command),
      .req_line_select       (req_line_select),
      .req_measured_flow     (req_measured_flow),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_dac_code          (rsp_dac_code),
      .rsp_valve_zero        (rsp_valve_zero),
      .rsp_valve_one         (rsp_valve_one),
      .rsp_ready_res         (rsp_ready_res),
      .rsp_not_reached_fault (rsp_not_reached_fault),
      .rsp_deviation_warning (rsp_deviation_warning),
      .rsp_deviation_fault   (rsp_deviation_fault),
      .rsp_phase             (rsp_phase),
      .rsp_event_res         (rsp_event_res),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Result side: long hold-off on request, otherwise random stall bursts while receiver_idling is set.
   initial begin : result_sink
      int held;
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
            hold_request = 1'b0;
         end else if (receiver_idling && $urandom_range(7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         model.check_status('{rsp_dac_code, rsp_valve_zero, rsp_valve_one, rsp_ready_res,
                              rsp_not_reached_fault, rsp_deviation_warning,
                              rsp_deviation_fault, rsp_phase, rsp_event_res});
   end

   // Abort when neither channel nor the register port moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("flow_controller_supervisor verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_request(input logic [1:0] cmd, input logic line,
                               input logic signed [FLOW_W-1:0] flow);
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_line_select   <= line;
      req_measured_flow <= flow;
      do @(posedge clock); while (req_stall);
      model.note_request(cmd, line, flow);
      if (sender_idling && $urandom_range(9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every owed status has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (model.pending.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      model.write_reg(idx, data);
   endtask

   task automatic apply_settings(input channel_settings_type s);
      csr_put(REG_SETPOINT,       CSR_DATA_W'(s.setpoint));
      csr_put(REG_WARN_FRACTION,  s.warn_fraction);
      csr_put(REG_FAULT_FRACTION, s.fault_fraction);
      csr_put(REG_SETTLE_LIMIT,   s.settle_limit);
      csr_put(REG_CONFIRM_LIMIT,  s.confirm_limit);
      csr_write <= 1'b0;
      @(posedge clock);
      cur = s;
   endtask

   function automatic channel_settings_type random_settings();
      channel_settings_type s;
      s.setpoint       = SETPOINT_W'($urandom);
      s.warn_fraction  = FRAC_W'($urandom_range(1000, 20000));
      s.fault_fraction = FRAC_W'($urandom_range(s.warn_fraction, 65535));
      s.settle_limit   = COUNT_W'($urandom_range(0, 20));
      s.confirm_limit  = COUNT_W'($urandom_range(0, 6));
      return s;
   endfunction

   // Flow sample spread over the tolerance bands and their edges, or a fully random one.
   function automatic logic signed [FLOW_W-1:0] pick_flow();
      int band_w;
      int band_f;
      int offset;
      int v;
      band_w = (int'(cur.setpoint) * int'(cur.warn_fraction)) >>> 16;
      band_f = (int'(cur.setpoint) * int'(cur.fault_fraction)) >>> 16;
      case ($urandom_range(6))
         0: offset = 0;
         1: offset = $urandom_range(0, band_w);
         2: offset = band_w + $urandom_range(1);
         3: offset = $urandom_range(band_w, band_f + 1);
         4: offset = band_f + $urandom_range(1);
         default: return FLOW_W'($urandom);
      endcase
      v = $urandom_range(1) ? int'(cur.setpoint) + offset : int'(cur.setpoint) - offset;
      if (v > 8191) v = 8191;
      if (v < -8192) v = -8192;
      return FLOW_W'(v);
   endfunction

   // Mostly start-led sequences of ticks, evaluations and an occasional off; now and then noise.
   task automatic run_random(input int count);
      int sent;
      int steps;
      int pick;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(9) == 0) begin
            steps = $urandom_range(1, 4);
            repeat (steps)
               send_request(2'($urandom_range(3)), 1'($urandom_range(1)), FLOW_W'($urandom));
            sent += steps;
         end else begin
            send_request(CMD_START, 1'($urandom_range(1)), FLOW_W'($urandom));
            sent++;
            steps = $urandom_range(4, 24);
            for (int i = 0; i < steps; i++) begin
               pick = $urandom_range(19);
               sent++;
               if (pick < 8) begin
                  send_request(CMD_TICK, 1'($urandom_range(1)), FLOW_W'($urandom));
               end else if (pick < 19) begin
                  send_request(CMD_EVALUATE, 1'($urandom_range(1)), pick_flow());
               end else begin
                  send_request(CMD_OFF, 1'($urandom_range(1)), FLOW_W'($urandom));
                  break;
               end
            end
         end
      end
   endtask

   initial begin : stimulus
      channel_settings_type s;
      cur = '{SETPOINT_RST, WARN_FRACTION_RST, FAULT_FRACTION_RST,
              SETTLE_LIMIT_RST, CONFIRM_LIMIT_RST};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // evaluate and off while idle, then a tick
      send_request(CMD_EVALUATE, 1'b1, FLOW_W'(0));
      send_request(CMD_OFF,      1'b0, FLOW_W'(0));
      send_request(CMD_TICK,     1'b1, FLOW_W'(0));
      drain();

      // warn band is 100, fault band 500 around 1000
      apply_settings('{13'd1000, 16'd6554, 16'd32768, 16'd2, 16'd1});
      send_request(CMD_START,    1'b0, FLOW_W'(0));
      send_request(CMD_EVALUATE, 1'b0, FLOW_W'(-8192));
      repeat (3) send_request(CMD_TICK, 1'b0, FLOW_W'(0));
      send_request(CMD_EVALUATE, 1'b0, FLOW_W'(8191));
      repeat (2) send_request(CMD_TICK, 1'b0, FLOW_W'(0));
      send_request(CMD_EVALUATE, 1'b0, FLOW_W'(1000));
      send_request(CMD_EVALUATE, 1'b0, FLOW_W'(1100));
      send_request(CMD_EVALUATE, 1'b0, FLOW_W'(1101));
      send_request(CMD_EVALUATE, 1'b0, FLOW_W'(1499));
      send_request(CMD_EVALUATE, 1'b0, FLOW_W'(1500));
      send_request(CMD_START,    1'b1, FLOW_W'(-1));
      drain();

      // setpoint change with the drive on: the code must follow it
      apply_settings('{13'd8191, 16'd65535, 16'd65535, 16'd0, 16'd0});
      send_request(CMD_TICK,     1'b0, FLOW_W'(0));
      send_request(CMD_EVALUATE, 1'b0, FLOW_W'(8191));
      send_request(CMD_EVALUATE, 1'b0, FLOW_W'(-8192));
      send_request(CMD_OFF,      1'b1, FLOW_W'(-1));
      send_request(CMD_EVALUATE, 1'b0, FLOW_W'(8191));
      drain();

      apply_settings('{13'd0, 16'd0, 16'd0, 16'd0, 16'd0});
      run_random(160);
      drain();

      apply_settings('{13'd8191, 16'd65535, 16'd65535, 16'd0, 16'd0});
      run_random(160);
      drain();

      // hold the result side off while requests keep coming
      apply_settings(random_settings());
      hold_request = 1'b1;
      run_random(160);
      drain();

      // pause the sender mid-phase until everything has come back
      apply_settings(random_settings());
      run_random(80);
      drain();
      run_random(80);
      drain();

      s = random_settings();
      s.settle_limit = COUNT_W'($urandom_range(0, 3));
      apply_settings(s);
      run_random(160);
      drain();

      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      apply_settings(random_settings());
      run_random(160);
      drain();
      repeat (8) @(posedge clock);

      if (model.failures == 0 && model.pending.size() == 0)
         $display("flow_controller_supervisor verification clean");
      else
         $display("flow_controller_supervisor verification failed");
      $finish;
   end

endmodule
